### sv/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types, constants and the reciprocal table of the RGB to HSV window
// filter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

   // fixed-point formats of hue and saturation
   localparam int HUE_FRAC_BITS = 4;
   localparam int SAT_FRAC_BITS = 12;

   localparam int CHAN_W = 8;
   localparam int HUE_W  = 13;
   localparam int SAT_W  = 13;
   localparam int VAL_W  = 8;

   localparam int SECTOR_DEGREES = 60;
   localparam int SECTORS        = 6;
   localparam int CHAN_MAX       = (1 << CHAN_W) - 1;

   // one sector of hue in output units
   localparam int HUE_UNIT = SECTOR_DEGREES << HUE_FRAC_BITS;

   // hue numerator stays below six times the chroma, or is zero for grey
   localparam int NUM_MAX = SECTORS * CHAN_MAX;
   localparam int NUM_W   = $clog2(NUM_MAX + 1);

   // dividends of the two divisions
   localparam int XH_W = $clog2(HUE_UNIT * NUM_MAX + 1);
   localparam int XS_W = CHAN_W + SAT_FRAC_BITS;

   // reciprocal ceil(2^RECIP_SHIFT / d) is exact for dividends below
   // 2^(RECIP_SHIFT - CHAN_W)
   localparam int RECIP_SHIFT = ((XH_W > XS_W) ? XH_W : XS_W) + CHAN_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_DEPTH = 1 << CHAN_W;

   localparam int PROD_H_W = XH_W + RECIP_W;
   localparam int PROD_S_W = XS_W + RECIP_W;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VAL_LOW  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_VAL_HIGH = 3'd5;

   localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 13'd640;
   localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 13'd2880;
   localparam logic [SAT_W-1:0] SAT_LOW_RESET  = 13'd410;
   localparam logic [SAT_W-1:0] SAT_HIGH_RESET = 13'd3686;
   localparam logic [VAL_W-1:0] VAL_LOW_RESET  = 8'd77;
   localparam logic [VAL_W-1:0] VAL_HIGH_RESET = 8'd178;

   localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(SECTORS * HUE_UNIT);
   localparam logic [SAT_W-1:0] SAT_LIMIT = SAT_W'(1 << SAT_FRAC_BITS);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic              keep;
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [VAL_W-1:0]  value_level;
   } rsp_payload_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
      logic [VAL_W-1:0] val;
   } hsv_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue_low;
      logic [HUE_W-1:0] hue_high;
      logic [SAT_W-1:0] sat_low;
      logic [SAT_W-1:0] sat_high;
      logic [VAL_W-1:0] val_low;
      logic [VAL_W-1:0] val_high;
   } cfg_type;

   typedef logic [RECIP_W-1:0] recip_table_type [RECIP_DEPTH];

   // ceil(2^RECIP_SHIFT / divisor) by restoring long division
   function automatic logic [RECIP_W-1:0] ceil_recip(int unsigned divisor);
      longint unsigned    num;
      longint unsigned    rem;
      logic [RECIP_W-1:0] quo;
      num = (longint'(1) << RECIP_SHIFT) + longint'(divisor) - 1;
      rem = 0;
      quo = '0;
      for (int k = RECIP_W - 1; k >= 0; k--) begin
         rem = (rem << 1) | ((num >> k) & 1);
         if (rem >= divisor) begin
            rem    = rem - divisor;
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic recip_table_type build_recip_table();
      recip_table_type tbl;
      tbl[0] = '0;
      for (int i = 1; i < RECIP_DEPTH; i++) begin
         tbl[i] = ceil_recip(i);
      end
      return tbl;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();

endpackage

### sv/rhsv_csr.sv
// ----------------------------------------------------------------------------
// rhsv_csr
// Window bound registers behind an APB-style port.
// ----------------------------------------------------------------------------
module rhsv_csr
   import rhsv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_HUE_LOW:  cfg_in.hue_low  = csr_pwdata[HUE_W-1:0];
            REG_HUE_HIGH: cfg_in.hue_high = csr_pwdata[HUE_W-1:0];
            REG_SAT_LOW:  cfg_in.sat_low  = csr_pwdata[SAT_W-1:0];
            REG_SAT_HIGH: cfg_in.sat_high = csr_pwdata[SAT_W-1:0];
            REG_VAL_LOW:  cfg_in.val_low  = csr_pwdata[VAL_W-1:0];
            REG_VAL_HIGH: cfg_in.val_high = csr_pwdata[VAL_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_low  <= HUE_LOW_RESET;
         cfg_ff.hue_high <= HUE_HIGH_RESET;
         cfg_ff.sat_low  <= SAT_LOW_RESET;
         cfg_ff.sat_high <= SAT_HIGH_RESET;
         cfg_ff.val_low  <= VAL_LOW_RESET;
         cfg_ff.val_high <= VAL_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_HUE_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.hue_low);
         REG_HUE_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.hue_high);
         REG_SAT_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.sat_low);
         REG_SAT_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.sat_high);
         REG_VAL_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.val_low);
         REG_VAL_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.val_high);
         default:      csr_prdata = '0;
      endcase
   end

endmodule

### sv/rhsv_convert.sv
// ----------------------------------------------------------------------------
// rhsv_convert
// Three-stage RGB to HSV conversion: extrema and hue numerator, reciprocal
// lookup, reciprocal multiply.
// ----------------------------------------------------------------------------
module rhsv_convert
   import rhsv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_payload_type in_payload,
   output logic            in_stall,
   output logic            out_valid,
   output hsv_type         out_hsv,
   input  logic            out_ready
);

   logic adv1;
   logic adv2;
   logic adv3;

   // stage 1: max, chroma, hue numerator
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0] s1_mx_ff, s1_mx_in;
   logic [CHAN_W-1:0] s1_d_ff, s1_d_in;
   logic [NUM_W-1:0]  s1_num_ff, s1_num_in;

   // stage 2: reciprocals and dividends
   logic               s2_valid_ff, s2_valid_in;
   logic [CHAN_W-1:0]  s2_mx_ff, s2_mx_in;
   logic [RECIP_W-1:0] s2_recip_m_ff, s2_recip_m_in;
   logic [RECIP_W-1:0] s2_recip_d_ff, s2_recip_d_in;
   logic [XH_W-1:0]    s2_xh_ff, s2_xh_in;
   logic [XS_W-1:0]    s2_xs_ff, s2_xs_in;

   // stage 3: quotients
   logic               s3_valid_ff, s3_valid_in;
   hsv_type            s3_hsv_ff, s3_hsv_in;
   logic [PROD_H_W-1:0] prod_h;
   logic [PROD_S_W-1:0] prod_s;

   logic [CHAN_W-1:0] red, green, blue, mn;

   assign adv3     = !s3_valid_ff || out_ready;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_stall = !adv1;

   assign s1_valid_in = adv1 ? in_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   assign red   = in_payload.red;
   assign green = in_payload.green;
   assign blue  = in_payload.blue;

   always_comb begin
      s1_mx_in = red;
      mn       = red;
      if (green > s1_mx_in) s1_mx_in = green;
      if (blue > s1_mx_in)  s1_mx_in = blue;
      if (green < mn)       mn = green;
      if (blue < mn)        mn = blue;
      s1_d_in = s1_mx_in - mn;
      // sector of the largest channel, red wins ties over green, green over blue
      if (s1_mx_in == red) begin
         if (green >= blue) begin
            s1_num_in = NUM_W'(green) - NUM_W'(blue);
         end else begin
            // negative red-sector hue wraps by six sectors
            s1_num_in = NUM_W'(green) + NUM_W'(s1_d_in) * NUM_W'(SECTORS)
                        - NUM_W'(blue);
         end
      end else if (s1_mx_in == green) begin
         s1_num_in = NUM_W'(blue) + (NUM_W'(s1_d_in) << 1) - NUM_W'(red);
      end else begin
         s1_num_in = NUM_W'(red) + (NUM_W'(s1_d_in) << 2) - NUM_W'(green);
      end
   end

   // grey and black need no special case: chroma zero gives zero dividends
   always_comb begin
      s2_mx_in      = s1_mx_ff;
      s2_recip_m_in = RECIP_TABLE[s1_mx_ff];
      s2_recip_d_in = RECIP_TABLE[s1_d_ff];
      s2_xh_in      = XH_W'(s1_num_ff) * XH_W'(HUE_UNIT);
      s2_xs_in      = {s1_d_ff, {SAT_FRAC_BITS{1'b0}}};
   end

   assign prod_h = PROD_H_W'(s2_xh_ff) * PROD_H_W'(s2_recip_d_ff);
   assign prod_s = PROD_S_W'(s2_xs_ff) * PROD_S_W'(s2_recip_m_ff);

   always_comb begin
      s3_hsv_in.hue = prod_h[RECIP_SHIFT +: HUE_W];
      s3_hsv_in.sat = prod_s[RECIP_SHIFT +: SAT_W];
      s3_hsv_in.val = s2_mx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_mx_ff  <= s1_mx_in;
         s1_d_ff   <= s1_d_in;
         s1_num_ff <= s1_num_in;
      end
      if (adv2) begin
         s2_mx_ff      <= s2_mx_in;
         s2_recip_m_ff <= s2_recip_m_in;
         s2_recip_d_ff <= s2_recip_d_in;
         s2_xh_ff      <= s2_xh_in;
         s2_xs_ff      <= s2_xs_in;
      end
      if (adv3) begin
         s3_hsv_ff <= s3_hsv_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_hsv   = s3_hsv_ff;

   hue_in_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_hsv_ff.hue < HUE_LIMIT)
      else $error("hue quotient out of range");

   sat_in_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_hsv_ff.sat <= SAT_LIMIT)
      else $error("saturation quotient out of range");

   last_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_ready |=> s3_valid_ff && $stable(s3_hsv_ff))
      else $error("last conversion stage changed while held");

endmodule

### sv/rhsv_window.sv
// ----------------------------------------------------------------------------
// rhsv_window
// Inclusive window test on hue, saturation and value, and the result register.
// ----------------------------------------------------------------------------
module rhsv_window
   import rhsv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_valid,
   input  hsv_type         in_hsv,
   output logic            in_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            rsp_stall
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            hue_ok, sat_ok, val_ok;

   assign in_ready = !rsp_valid_ff || !rsp_stall;

   assign hue_ok = (in_hsv.hue >= cfg.hue_low) && (in_hsv.hue <= cfg.hue_high);
   assign sat_ok = (in_hsv.sat >= cfg.sat_low) && (in_hsv.sat <= cfg.sat_high);
   assign val_ok = (in_hsv.val >= cfg.val_low) && (in_hsv.val <= cfg.val_high);

   always_comb begin
      rsp_valid_in               = in_ready ? in_valid : rsp_valid_ff;
      rsp_payload_in.keep        = hue_ok && sat_ok && val_ok;
      rsp_payload_in.hue         = in_hsv.hue;
      rsp_payload_in.saturation  = in_hsv.sat;
      rsp_payload_in.value_level = in_hsv.val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### sv/rgb_to_hsv_range_filter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_range_filter_unit
// Converts an 8-bit RGB color to HSV and flags colors inside a window.
// ----------------------------------------------------------------------------
// Takes one color every cycle while the result side does not stall and
// returns one result per color, in order. A color passes through three
// conversion stages (extrema and hue numerator, reciprocal lookup,
// reciprocal multiply) and the window test feeding the result register.
// Both divisions are done as exact multiplies by a constant reciprocal of
// the 8-bit divisor. Stalls back up through the stages one at a time, so
// req_stall rises only when every stage holds an item. The user must write
// window bounds through the csr port only while no item is in flight; the
// block itself does not enforce it. No clearing or warm-up is needed after
// reset.
module rgb_to_hsv_range_filter_unit
   import rhsv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_payload_type       req_payload,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload,
   input  logic                  rsp_stall,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   logic    conv_valid;
   hsv_type conv_hsv;
   logic    win_ready;

   rhsv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rhsv_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_payload (req_payload),
      .in_stall   (req_stall),
      .out_valid  (conv_valid),
      .out_hsv    (conv_hsv),
      .out_ready  (win_ready)
   );

   rhsv_window u_window (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (conv_valid),
      .in_hsv      (conv_hsv),
      .in_ready    (win_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule
